>>> rtl/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg : shared types and constants of the +IPD frame parser
// Word format between the front classifier, the queue and the parser back end,
// the result record, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ipd_pkg;

	// input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result status codes
	localparam logic [1:0] ST_PAYLOAD = 2'd0;
	localparam logic [1:0] ST_BAD_ID  = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam int          CFG_INDEX_W      = 2;
	localparam int          CFG_DATA_W       = 32;
	localparam logic [1:0]  CFG_HDR_TIMEOUT  = 2'd0;
	localparam logic [1:0]  CFG_PAY_TIMEOUT  = 2'd1;
	localparam logic [1:0]  CFG_BUF_CAPACITY = 2'd2;

	// configuration reset values
	localparam logic [31:0] HDR_TIMEOUT_RST  = 32'd5000;
	localparam logic [15:0] PAY_TIMEOUT_RST  = 16'd3000;
	localparam logic [15:0] BUF_CAPACITY_RST = 16'd1024;

	// field widths fixed by the interface
	localparam int BYTE_W   = 8;
	localparam int OUT_LEN_W = 16;
	localparam int CFG16_W  = 16;
	localparam int TICK_W   = 32;
	localparam int ID_W     = 3;

	// header text "+IPD," ; entry 0 is the first character
	localparam int                        HDR_LEN  = 5;
	localparam int                        MATCH_W  = 3;
	localparam logic [HDR_LEN-1:0][7:0]   HDR_TEXT = {8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B};

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// classified input word
	typedef struct packed {
		logic               is_tick;
		logic [7:0]         data;
		logic               is_digit;
		logic [3:0]         digit;
		logic               is_colon;
		logic               is_comma;
		logic               is_minus;
		logic               is_plus;
		logic [HDR_LEN-1:0] hdr_eq;
	} word_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// one result word
	typedef struct packed {
		logic [1:0]           status;
		logic [7:0]           data;
		logic                 last;
		logic [OUT_LEN_W-1:0] len;
		logic [ID_W-1:0]      id;
		logic                 idp;
	} res_t;

endpackage

>>> rtl/ipd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_front : input classifier
// Takes input words, decodes the byte into character classes and header
// character matches, and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module ipd_front
	import ipd_pkg::*;
(
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	input  qstat_t     qstat,
	output logic       push,
	output word_t      push_word
);

	// accept whenever the queue has room
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	// character classification
	always_comb begin
		logic [7:0] dig;
		dig = rx_byte - CHAR_ZERO;
		push_word.is_tick  = (operation == OP_TICK);
		push_word.data     = rx_byte;
		push_word.is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
		push_word.digit    = dig[3:0];
		push_word.is_colon = (rx_byte == CHAR_COLON);
		push_word.is_comma = (rx_byte == CHAR_COMMA);
		push_word.is_minus = (rx_byte == CHAR_MINUS);
		push_word.is_plus  = (rx_byte == CHAR_PLUS);
		for (int i = 0; i < HDR_LEN; i++) begin
			push_word.hdr_eq[i] = (rx_byte == HDR_TEXT[i]);
		end
	end

endmodule

>>> rtl/ipd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_queue : short word queue
// Four-entry queue between the classifier and the parser so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module ipd_queue
	import ipd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  word_t  push_word,
	input  logic   pop,
	output word_t  head,
	output qstat_t qstat
);

	word_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ipd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_back : header parser and payload sequencer
// Takes one classified word a cycle from the queue while no result is held back,
// runs the header search, the decimal number fields, the payload keep/drop counts and
// both timeouts, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module ipd_back
	import ipd_pkg::*;
#(
	parameter int LENGTH_BITS = 16,
	parameter int MAX_LINK_ID = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  qstat_t                 qstat,
	input  word_t                  head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output res_t                   res
);

	localparam int L     = LENGTH_BITS;
	localparam int CMP_W = (L > CFG16_W) ? L : CFG16_W;

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_SECOND = 3'd2;
	localparam logic [2:0] PH_KEEP   = 3'd3;
	localparam logic [2:0] PH_DROP   = 3'd4;

	// configuration
	logic [TICK_W-1:0]  hdr_to_q;
	logic [CFG16_W-1:0] pay_to_q;
	logic [CFG16_W-1:0] cap_q;

	// parser state
	logic [2:0]         phase_q, phase_d;
	logic [MATCH_W-1:0] match_q, match_d;
	logic [L-1:0]       acc_q, acc_d;
	logic               seen_q, seen_d;
	logic               neg_q, neg_d;
	logic               stop_q, stop_d;
	logic [L-1:0]       first_mag_q, first_mag_d;
	logic               first_neg_q, first_neg_d;
	logic [ID_W-1:0]    saved_id_q, saved_id_d;
	logic               has_id_q, has_id_d;
	logic [L-1:0]       flen_q, flen_d;
	logic [L-1:0]       keep_q, keep_d;
	logic [L-1:0]       drop_q, drop_d;
	logic [TICK_W-1:0]  tick_q, tick_d;

	// result register
	logic out_valid_q;
	res_t res_q;
	res_t res_d;
	logic res_fire;

	logic out_free;

	// decimal multiply-add with saturation
	logic [L+3:0] acc_x10;
	logic [L-1:0] acc_next;

	// length bookkeeping
	logic [CMP_W-1:0] cap_x, len_x, keep_x, flen_x;
	logic [TICK_W-1:0] tick_inc;
	logic              id_bad, len_bad;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !qstat.empty && out_free;

	assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (L+4)'(head.digit);
	assign acc_next = (acc_x10[L+3:L] != '0) ? '1 : acc_x10[L-1:0];

	assign cap_x  = CMP_W'((cap_q == '0) ? 16'd1 : cap_q);
	assign len_x  = CMP_W'(acc_q);
	assign keep_x = (len_x > cap_x) ? cap_x : len_x;
	assign flen_x = CMP_W'(flen_q);

	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;

	assign id_bad  = has_id_q && ((first_neg_q && first_mag_q != '0) ||
		(first_mag_q > L'(MAX_LINK_ID)));
	assign len_bad = neg_q || (acc_q == '0);

	// next-state and result logic for the word at the queue head
	always_comb begin
		logic restart;
		restart     = 1'b0;
		phase_d     = phase_q;
		match_d     = match_q;
		acc_d       = acc_q;
		seen_d      = seen_q;
		neg_d       = neg_q;
		stop_d      = stop_q;
		first_mag_d = first_mag_q;
		first_neg_d = first_neg_q;
		saved_id_d  = saved_id_q;
		has_id_d    = has_id_q;
		flen_d      = flen_q;
		keep_d      = keep_q;
		drop_d      = drop_q;
		tick_d      = tick_q;
		res_fire    = 1'b0;
		res_d       = '0;

		if (head.is_tick) begin
			// millisecond tick: timeouts
			tick_d = tick_inc;
			if (phase_q == PH_KEEP) begin
				if (tick_inc >= TICK_W'(pay_to_q)) begin
					restart      = 1'b1;
					res_fire     = 1'b1;
					res_d.status = ST_TIMEOUT;
					res_d.len    = flen_x[OUT_LEN_W-1:0];
					res_d.id     = saved_id_q;
					res_d.idp    = has_id_q;
				end
			end else if (phase_q == PH_DROP) begin
				if (tick_inc >= TICK_W'(pay_to_q)) begin
					restart = 1'b1;
				end
			end else if (tick_inc >= hdr_to_q) begin
				restart      = 1'b1;
				res_fire     = 1'b1;
				res_d.status = ST_TIMEOUT;
			end
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (head.hdr_eq[match_q]) begin
						if (match_q == MATCH_W'(HDR_LEN - 1)) begin
							match_d = '0;
							acc_d   = '0;
							seen_d  = 1'b0;
							neg_d   = 1'b0;
							stop_d  = 1'b0;
							phase_d = PH_FIRST;
						end else begin
							match_d = match_q + 1'b1;
						end
					end else begin
						match_d = head.is_plus ? MATCH_W'(1) : '0;
					end
				end
				PH_FIRST, PH_SECOND: begin
					if (head.is_colon) begin
						// end of header: check id, then length
						if (id_bad) begin
							restart      = 1'b1;
							res_fire     = 1'b1;
							res_d.status = ST_BAD_ID;
							res_d.idp    = 1'b1;
						end else if (len_bad) begin
							restart      = 1'b1;
							res_fire     = 1'b1;
							res_d.status = ST_BAD_LEN;
							res_d.id     = has_id_q ? first_mag_q[ID_W-1:0] : '0;
							res_d.idp    = has_id_q;
						end else begin
							saved_id_d = has_id_q ? first_mag_q[ID_W-1:0] : '0;
							flen_d     = acc_q;
							keep_d     = keep_x[L-1:0];
							drop_d     = acc_q - keep_x[L-1:0];
							tick_d     = '0;
							phase_d    = PH_KEEP;
						end
					end else if (head.is_comma && phase_q == PH_FIRST) begin
						// id field done, length follows
						first_mag_d = acc_q;
						first_neg_d = neg_q;
						has_id_d    = 1'b1;
						acc_d       = '0;
						seen_d      = 1'b0;
						neg_d       = 1'b0;
						stop_d      = 1'b0;
						phase_d     = PH_SECOND;
					end else if (!stop_q) begin
						// number character
						if (!seen_q && head.is_minus) begin
							seen_d = 1'b1;
							neg_d  = 1'b1;
						end else if (head.is_digit) begin
							acc_d  = acc_next;
							seen_d = 1'b1;
						end else begin
							seen_d = 1'b1;
							stop_d = 1'b1;
						end
					end
				end
				PH_KEEP: begin
					// deliver a payload byte
					keep_d       = keep_q - 1'b1;
					res_fire     = 1'b1;
					res_d.status = ST_PAYLOAD;
					res_d.data   = head.data;
					res_d.len    = flen_x[OUT_LEN_W-1:0];
					res_d.id     = saved_id_q;
					res_d.idp    = has_id_q;
					if (keep_q == L'(1)) begin
						res_d.last = 1'b1;
						if (drop_q == '0) begin
							restart = 1'b1;
						end else begin
							phase_d = PH_DROP;
						end
					end
				end
				PH_DROP: begin
					// discard surplus bytes
					drop_d = drop_q - 1'b1;
					if (drop_q == L'(1)) begin
						restart = 1'b1;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end

		if (restart) begin
			phase_d     = PH_SEARCH;
			match_d     = '0;
			acc_d       = '0;
			seen_d      = 1'b0;
			neg_d       = 1'b0;
			stop_d      = 1'b0;
			first_mag_d = '0;
			first_neg_d = 1'b0;
			saved_id_d  = '0;
			has_id_d    = 1'b0;
			flen_d      = '0;
			keep_d      = '0;
			drop_d      = '0;
			tick_d      = '0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_to_q <= HDR_TIMEOUT_RST;
			pay_to_q <= PAY_TIMEOUT_RST;
			cap_q    <= BUF_CAPACITY_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HDR_TIMEOUT:  hdr_to_q <= cfg_data;
				CFG_PAY_TIMEOUT:  pay_to_q <= cfg_data[CFG16_W-1:0];
				CFG_BUF_CAPACITY: cap_q    <= cfg_data[CFG16_W-1:0];
				default: ;
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH;
			match_q     <= '0;
			acc_q       <= '0;
			seen_q      <= 1'b0;
			neg_q       <= 1'b0;
			stop_q      <= 1'b0;
			first_mag_q <= '0;
			first_neg_q <= 1'b0;
			saved_id_q  <= '0;
			has_id_q    <= 1'b0;
			flen_q      <= '0;
			keep_q      <= '0;
			drop_q      <= '0;
			tick_q      <= '0;
		end else if (pop) begin
			phase_q     <= phase_d;
			match_q     <= match_d;
			acc_q       <= acc_d;
			seen_q      <= seen_d;
			neg_q       <= neg_d;
			stop_q      <= stop_d;
			first_mag_q <= first_mag_d;
			first_neg_q <= first_neg_d;
			saved_id_q  <= saved_id_d;
			has_id_q    <= has_id_d;
			flen_q      <= flen_d;
			keep_q      <= keep_d;
			drop_q      <= drop_d;
			tick_q      <= tick_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pop && res_fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// checks
	a_keep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_KEEP |-> keep_q != '0)
		else $error("payload phase with no bytes left to keep");

	a_drop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DROP |-> drop_q != '0)
		else $error("drop phase with no bytes left to drop");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		match_q < MATCH_W'(HDR_LEN))
		else $error("header match position out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("word taken from an empty queue");

	a_result_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && !pop) |=> !out_valid_q)
		else $error("result appeared without a word being parsed");

endmodule

>>> rtl/ipd_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_frame_parser : streaming +IPD frame parser
// Hunts for "+IPD," in a received byte stream, reads "id,len:" or "len:",
// checks them, delivers up to buffer_capacity payload bytes with the last
// one marked, drops the rest, and reports header and keep-phase payload timeouts.
//
//  channel | direction | handshake            | words
//  in      | input     | in_valid / in_stall  | operation, rx_byte
//  out     | output    | out_valid / out_stall| status, payload_byte, last_byte,
//          |           |                      | declared_length, link_id, id_present
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One input word per cycle while out_stall stays low; the parser handles
// one word a cycle with a single decimal multiply-add by ten on the accumulator.
// An accepted word is written into the queue, taken by the parser after the
// words ahead of it, and its result is registered in the register behind out_valid.
// A four-word queue separates input from parser; in_stall rises only when it
// is full, and out_stall holds the parser while a result waits.
// arst_n clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module ipd_frame_parser
	import ipd_pkg::*;
#(
	parameter int LENGTH_BITS = 16,
	parameter int MAX_LINK_ID = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [7:0]             payload_byte,
	output logic                   last_byte,
	output logic [OUT_LEN_W-1:0]   declared_length,
	output logic [ID_W-1:0]        link_id,
	output logic                   id_present
);

	qstat_t qstat;
	logic   push;
	word_t  push_word;
	logic   pop;
	word_t  head;
	res_t   res;

	// input classifier
	ipd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.rx_byte   (rx_byte),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	// decoupling queue
	ipd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// parser back end
	ipd_back #(
		.LENGTH_BITS (LENGTH_BITS),
		.MAX_LINK_ID (MAX_LINK_ID)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign status          = res.status;
	assign payload_byte    = res.data;
	assign last_byte       = res.last;
	assign declared_length = res.len;
	assign link_id         = res.id;
	assign id_present      = res.idp;

endmodule

>>> tb/sv/ipd_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_frame_parser_tb : self-checking testbench of the +IPD frame parser
// Feeds received bytes and millisecond ticks, predicts every result word with
// an in-bench parser model and checks each result field by field. Directed
// tests cover header checks, saturation, timeouts and zero registers; random
// frames with noise, broken headers and tick bursts run under several
// register settings with random idling on both channels and one long hold.
// ----------------------------------------------------------------------------
module ipd_frame_parser_tb;
	import ipd_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int LEN_BITS      = 16;
	localparam int MAX_ID        = 4;

	// parser phases of the bench model
	typedef enum logic [2:0] {
		HUNT_HDR,
		READ_FIRST,
		READ_LEN,
		KEEP_BYTES,
		DROP_BYTES
	} parse_phase_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic                   operation = OP_BYTE;
	logic [7:0]             rx_byte   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic [7:0]             payload_byte;
	logic                   last_byte;
	logic [OUT_LEN_W-1:0]   declared_length;
	logic [ID_W-1:0]        link_id;
	logic                   id_present;

	// model registers
	logic [31:0] hdr_limit;
	logic [15:0] pay_limit;
	logic [15:0] buf_cap;

	// model parser state
	parse_phase_t phase;
	logic [2:0]   match_cnt;
	logic [15:0]  num_val;
	logic         num_seen, num_neg, num_stop;
	logic [15:0]  first_mag;
	logic         first_neg;
	logic [2:0]   id_reg;
	logic         id_flag;
	logic [15:0]  frame_len;
	logic [15:0]  keep_left;
	logic [15:0]  drop_left;
	logic [31:0]  tick_cnt;

	res_t parsed_q[$];

	int  errors       = 0;
	int  words_sent   = 0;
	int  cycles       = 0;
	int  status_seen[4];
	bit  gaps_on      = 1'b1;
	int  tick_pct     = 4;
	bit  hold_tgl     = 1'b0;
	bit  hold_seen    = 1'b0;
	int  hold_left    = 0;

	ipd_frame_parser #(
		.LENGTH_BITS(LEN_BITS),
		.MAX_LINK_ID(MAX_ID)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.payload_byte   (payload_byte),
		.last_byte      (last_byte),
		.declared_length(declared_length),
		.link_id        (link_id),
		.id_present     (id_present)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	function automatic void clear_frame();
		phase     = HUNT_HDR;
		match_cnt = '0;
		num_val   = '0;
		num_seen  = 1'b0;
		num_neg   = 1'b0;
		num_stop  = 1'b0;
		first_mag = '0;
		first_neg = 1'b0;
		id_reg    = '0;
		id_flag   = 1'b0;
		frame_len = '0;
		keep_left = '0;
		drop_left = '0;
		tick_cnt  = '0;
	endfunction

	function automatic void emit_result(logic [1:0] st, logic [7:0] d, logic l,
			logic [15:0] n, logic [2:0] i, logic p);
		res_t r;
		r.status = st;
		r.data   = d;
		r.last   = l;
		r.len    = n;
		r.id     = i;
		r.idp    = p;
		parsed_q.push_back(r);
	endfunction

	// one character of a decimal field: optional leading minus, saturating digits
	function automatic void number_char(logic [7:0] c);
		int unsigned acc;
		if (num_stop)
			return;
		if (!num_seen && c == CHAR_MINUS) begin
			num_seen = 1'b1;
			num_neg  = 1'b1;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			acc      = 32'(num_val) * 10 + 32'(c - CHAR_ZERO);
			num_val  = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
			num_seen = 1'b1;
		end else begin
			num_seen = 1'b1;
			num_stop = 1'b1;
		end
	endfunction

	// colon seen: check id and length, then enter the payload
	function automatic void finish_header();
		logic [2:0]  i;
		logic        p;
		logic [15:0] cap;
		if (id_flag) begin
			if ((first_neg && first_mag != 0) || first_mag > MAX_ID) begin
				clear_frame();
				emit_result(ST_BAD_ID, 8'h00, 1'b0, 16'h0, 3'd0, 1'b1);
				return;
			end
			id_reg = first_mag[2:0];
		end
		if (num_neg || num_val == 0) begin
			i = id_reg;
			p = id_flag;
			clear_frame();
			emit_result(ST_BAD_LEN, 8'h00, 1'b0, 16'h0, i, p);
			return;
		end
		frame_len = num_val;
		cap       = (buf_cap == 0) ? 16'd1 : buf_cap;
		keep_left = (frame_len > cap) ? cap : frame_len;
		drop_left = frame_len - keep_left;
		tick_cnt  = '0;
		phase     = KEEP_BYTES;
	endfunction

	function automatic void parse_word(logic op, logic [7:0] c);
		logic [15:0] n;
		logic [2:0]  i;
		logic        p;
		logic        l;
		n = frame_len;
		i = id_reg;
		p = id_flag;
		if (op == OP_TICK) begin
			if (tick_cnt != 32'hFFFF_FFFF)
				tick_cnt++;
			if (phase == KEEP_BYTES) begin
				if (tick_cnt >= 32'(pay_limit)) begin
					clear_frame();
					emit_result(ST_TIMEOUT, 8'h00, 1'b0, n, i, p);
				end
			end else if (phase == DROP_BYTES) begin
				if (tick_cnt >= 32'(pay_limit))
					clear_frame();
			end else if (tick_cnt >= hdr_limit) begin
				clear_frame();
				emit_result(ST_TIMEOUT, 8'h00, 1'b0, 16'h0, 3'd0, 1'b0);
			end
			return;
		end
		case (phase)
			HUNT_HDR: begin
				if (match_cnt < HDR_LEN && c == HDR_TEXT[match_cnt])
					match_cnt++;
				else
					match_cnt = (c == CHAR_PLUS) ? 3'd1 : 3'd0;
				if (match_cnt >= HDR_LEN) begin
					match_cnt = '0;
					num_val   = '0;
					{num_seen, num_neg, num_stop} = '0;
					phase     = READ_FIRST;
				end
			end
			READ_FIRST: begin
				if (c == CHAR_COLON)
					finish_header();
				else if (c == CHAR_COMMA) begin
					first_mag = num_val;
					first_neg = num_neg;
					id_flag   = 1'b1;
					num_val   = '0;
					{num_seen, num_neg, num_stop} = '0;
					phase     = READ_LEN;
				end else
					number_char(c);
			end
			READ_LEN: begin
				if (c == CHAR_COLON)
					finish_header();
				else
					number_char(c);
			end
			KEEP_BYTES: begin
				l = 1'b0;
				if (keep_left > 0)
					keep_left--;
				if (keep_left == 0) begin
					l = 1'b1;
					if (drop_left == 0)
						clear_frame();
					else
						phase = DROP_BYTES;
				end
				emit_result(ST_PAYLOAD, c, l, n, i, p);
			end
			default: begin
				if (drop_left > 0)
					drop_left--;
				if (drop_left == 0)
					clear_frame();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (parsed_q.size() == 0)
				report_mismatch("result word with nothing expected");
			else begin
				want = parsed_q.pop_front();
				status_seen[want.status]++;
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (payload_byte !== want.data)
					report_mismatch($sformatf("payload_byte %h, expected %h",
						payload_byte, want.data));
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte %b, expected %b", last_byte, want.last));
				if (declared_length !== want.len)
					report_mismatch($sformatf("declared_length %0d, expected %0d",
						declared_length, want.len));
				if (link_id !== want.id)
					report_mismatch($sformatf("link_id %0d, expected %0d", link_id, want.id));
				if (id_present !== want.idp)
					report_mismatch($sformatf("id_present %b, expected %b",
						id_present, want.idp));
			end
		end
	end

	// receiver: random stall, or a long hold when requested
	always @(posedge clk) begin
		if (hold_tgl != hold_seen) begin
			hold_seen = hold_tgl;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= gaps_on && ($urandom_range(99) < 38);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles, %0d results still expected",
				cycles, parsed_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic feed_word(input logic op, input logic [7:0] b);
		if (gaps_on) begin
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		operation <= op;
		rx_byte   <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_word(op, b);
		words_sent++;
	endtask

	// byte with an occasional tick in front of it
	task automatic feed_byte(input logic [7:0] b);
		if (tick_pct > 0 && $urandom_range(99) < tick_pct)
			feed_word(OP_TICK, 8'($urandom_range(255)));
		feed_word(OP_BYTE, b);
	endtask

	task automatic feed_text(input string s);
		for (int k = 0; k < s.len(); k++)
			feed_byte(s[k]);
	endtask

	task automatic feed_ticks(input int n);
		repeat (n) feed_word(OP_TICK, 8'($urandom_range(255)));
	endtask

	// stop sending and let every pending result and queued word drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] hdr, input logic [15:0] pay,
			input logic [15:0] cap);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_HDR_TIMEOUT;
		cfg_data  <= hdr;
		@(posedge clk);
		hdr_limit = hdr;
		cfg_index <= CFG_PAY_TIMEOUT;
		cfg_data  <= {16'h0, pay};
		@(posedge clk);
		pay_limit = pay;
		cfg_index <= CFG_BUF_CAPACITY;
		cfg_data  <= {16'h0, cap};
		@(posedge clk);
		buf_cap = cap;
		cfg_write <= 1'b0;
	endtask

	// one random frame: noise, maybe broken header, random id and length
	task automatic rand_frame();
		string       hdr;
		int unsigned pick;
		int          n_bytes;
		bit          long_tail;
		long_tail = 1'b0;
		repeat ($urandom_range(2)) feed_byte(8'($urandom_range(255)));
		if ($urandom_range(99) < 10)
			feed_ticks($urandom_range(1, 30));
		if ($urandom_range(99) < 8)
			hdr = "+IP";
		else
			hdr = "+IPD,";
		// id field
		if ($urandom_range(99) < 55) begin
			pick = $urandom_range(99);
			if (pick < 75)
				hdr = {hdr, $sformatf("%0d", $urandom_range(MAX_ID))};
			else if (pick < 88)
				hdr = {hdr, $sformatf("%0d", $urandom_range(5, 300))};
			else
				hdr = {hdr, $sformatf("-%0d", $urandom_range(3))};
			hdr = {hdr, ","};
		end
		// length field
		pick = $urandom_range(99);
		if (pick < 72) begin
			n_bytes = $urandom_range(1, 8);
			hdr = {hdr, $sformatf("%0d", n_bytes)};
		end else if (pick < 82) begin
			n_bytes = $urandom_range(9, 24);
			hdr = {hdr, $sformatf("%0d", n_bytes)};
		end else if (pick < 90 && pay_limit <= 200) begin
			n_bytes   = $urandom_range(1, 6);
			long_tail = 1'b1;
			hdr = {hdr, $sformatf("%0d", $urandom_range(65536, 999999))};
		end else begin
			n_bytes = 0;
			case ($urandom_range(2))
				0: hdr = {hdr, "0"};
				1: hdr = {hdr, $sformatf("-%0d", $urandom_range(9))};
				default: ;
			endcase
		end
		if ($urandom_range(99) < 8)
			hdr = {hdr, "x7"};
		hdr = {hdr, ":"};
		feed_text(hdr);
		// short payload now and then, left to the payload timeout
		if (pay_limit <= 200 && n_bytes > 1 && $urandom_range(99) < 6) begin
			n_bytes   = n_bytes - 1;
			long_tail = 1'b1;
		end
		repeat (n_bytes) feed_byte(8'($urandom_range(255)));
		if (long_tail)
			feed_ticks(int'(pay_limit) + 1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_default_frames();
		feed_text("+IPD,0,3:");
		feed_byte(8'h00);
		feed_byte(8'hFF);
		feed_byte(8'h5A);
		feed_text("+IPD,2:+I");
		feed_text("++IP+IPD,4,1:");
		feed_byte(8'h80);
	endtask

	task automatic test_header_checks();
		feed_text("+IPD,5,1:");
		feed_text("+IPD,-2,1:");
		feed_text("+IPD,-0,1:z");
		feed_text("+IPD,0:");
		feed_text("+IPD,3,-4:");
		feed_text("+IPD,1,-0:");
		feed_text("+IPD,2x7,1q5:a");
		feed_text("+IPD,1,2,8:bc");
	endtask

	task automatic test_timeouts();
		write_regs(32'd3, 16'd2, 16'd2);
		tick_pct = 0;
		feed_ticks(3);
		feed_text("+IP");
		feed_ticks(3);
		// saturated length, two bytes kept, drop ended by the payload timeout
		feed_text("+IPD,3,70000:ab");
		feed_ticks(2);
		feed_text("+IPD,4:x");
		feed_ticks(2);
		// zero registers: timeouts fire on the first tick, capacity acts as one
		write_regs(32'd0, 16'd0, 16'd0);
		feed_ticks(1);
		feed_text("+IPD,3:q");
		feed_ticks(1);
		feed_text("+IPD,2:");
		feed_ticks(1);
	endtask

	task automatic test_backpressure();
		write_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		gaps_on  = 1'b0;
		hold_tgl = ~hold_tgl;
		feed_text("+IPD,1,40:");
		repeat (40) feed_byte(8'($urandom_range(255)));
		wait_idle();
		gaps_on  = 1'b1;
	endtask

	task automatic run_random_phase(input logic [31:0] hdr, input logic [15:0] pay,
			input logic [15:0] cap, input bit gaps, input int target);
		int start;
		write_regs(hdr, pay, cap);
		gaps_on  = gaps;
		tick_pct = 4;
		start    = words_sent;
		while (words_sent - start < target)
			rand_frame();
		wait_idle();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		run_random_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 50);
		run_random_phase(32'd1, 16'd1, 16'd1, 1'b1, 30);
		run_random_phase(32'($urandom_range(8, 60)), 16'($urandom_range(3, 40)),
			16'($urandom_range(1, 6)), 1'b0, 50);
		run_random_phase(32'($urandom_range(8, 60)), 16'($urandom_range(3, 40)),
			16'($urandom_range(1, 6)), 1'b1, 50);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		hdr_limit = HDR_TIMEOUT_RST;
		pay_limit = PAY_TIMEOUT_RST;
		buf_cap   = BUF_CAPACITY_RST;
		clear_frame();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_frames();
		test_header_checks();
		test_timeouts();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		$display("Covered %0d input words: %0d payload, %0d bad id, %0d bad length, %0d timeout",
			words_sent, status_seen[ST_PAYLOAD], status_seen[ST_BAD_ID],
			status_seen[ST_BAD_LEN], status_seen[ST_TIMEOUT]);
		$display("Registers at reset, zero, minimum, maximum and random values; %0d mismatches",
			errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/ipd_pkg.sv
rtl/ipd_front.sv
rtl/ipd_queue.sv
rtl/ipd_back.sv
rtl/ipd_frame_parser.sv
tb/sv/ipd_frame_parser_tb.sv
